### rtl/core/sri_pkg.sv
package sri_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned CfgIdxBits   = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_e;

  // per-rectangle flags worked out next to the corner adders
  // reject[i]: both line endpoints strictly on one side of the line through edge i
  typedef struct packed {
    logic       pt_in;
    logic [3:0] reject;
  } geom_flags_t;

  // side of the alarm line on which each corner lies
  typedef struct packed {
    logic [3:0] pos;
    logic [3:0] neg;
  } corner_sign_t;

endpackage

### rtl/core/sri_setup.sv
module sri_setup #(
  parameter int unsigned CoordBits = sri_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [CoordBits-1:0]        box_left_i,
  input  logic [CoordBits-1:0]        box_top_i,
  input  logic [CoordBits-1:0]        box_width_i,
  input  logic [CoordBits-1:0]        box_height_i,
  input  logic [CoordBits-1:0]        ax_i,
  input  logic [CoordBits-1:0]        ay_i,
  input  logic [CoordBits-1:0]        bx_i,
  input  logic [CoordBits-1:0]        by_i,
  output logic                        valid_o,
  output logic [CoordBits-1:0]        x0_o,
  output logic [CoordBits-1:0]        y0_o,
  output logic [CoordBits:0]          x1_o,
  output logic [CoordBits:0]          y1_o,
  output logic signed [CoordBits:0]   dya_o,
  output logic signed [CoordBits:0]   dxb_o,
  output sri_pkg::geom_flags_t        flags_o
);
  import sri_pkg::*;

  localparam int unsigned WideBits = CoordBits + 1;

  logic                       valid_q;
  logic [CoordBits-1:0]       x0_q, y0_q;
  logic [WideBits-1:0]        x1_d, y1_d, x1_q, y1_q;
  logic signed [WideBits-1:0] dya_d, dxb_d, dya_q, dxb_q;
  logic [WideBits-1:0]        x0_w, y0_w, ax_w, ay_w, bx_w, by_w;
  geom_flags_t                flags_d, flags_q;

  function automatic logic pt_inside(input logic [WideBits-1:0] px, input logic [WideBits-1:0] py,
                                     input logic [WideBits-1:0] lx, input logic [WideBits-1:0] ly,
                                     input logic [WideBits-1:0] hx, input logic [WideBits-1:0] hy);
    return (px >= lx) && (px < hx) && (py >= ly) && (py < hy);
  endfunction

  function automatic logic same_side(input logic [WideBits-1:0] p, input logic [WideBits-1:0] q,
                                     input logic [WideBits-1:0] ref_v);
    return ((p < ref_v) && (q < ref_v)) || ((p > ref_v) && (q > ref_v));
  endfunction

  always_comb begin
    x0_w  = {1'b0, box_left_i};
    y0_w  = {1'b0, box_top_i};
    ax_w  = {1'b0, ax_i};
    ay_w  = {1'b0, ay_i};
    bx_w  = {1'b0, bx_i};
    by_w  = {1'b0, by_i};
    // far corner kept one bit wider so it never wraps
    x1_d  = x0_w + {1'b0, box_width_i};
    y1_d  = y0_w + {1'b0, box_height_i};
    dya_d = $signed(ay_w) - $signed(by_w);
    dxb_d = $signed(bx_w) - $signed(ax_w);

    flags_d.pt_in     = pt_inside(ax_w, ay_w, x0_w, y0_w, x1_d, y1_d) ||
                        pt_inside(bx_w, by_w, x0_w, y0_w, x1_d, y1_d);
    // a zero-length edge has zero cross products and never rejects
    flags_d.reject[0] = (box_width_i != '0) && same_side(ay_w, by_w, y0_w);
    flags_d.reject[1] = (box_height_i != '0) && same_side(ax_w, bx_w, x1_d);
    flags_d.reject[2] = (box_width_i != '0) && same_side(ay_w, by_w, y1_d);
    flags_d.reject[3] = (box_height_i != '0) && same_side(ax_w, bx_w, x0_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= box_left_i;
      y0_q    <= box_top_i;
      x1_q    <= x1_d;
      y1_q    <= y1_d;
      dya_q   <= dya_d;
      dxb_q   <= dxb_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign x0_o    = x0_q;
  assign y0_o    = y0_q;
  assign x1_o    = x1_q;
  assign y1_o    = y1_q;
  assign dya_o   = dya_q;
  assign dxb_o   = dxb_q;
  assign flags_o = flags_q;

endmodule

### rtl/core/sri_cross.sv
module sri_cross #(
  parameter int unsigned CoordBits = sri_pkg::CoordBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [CoordBits-1:0]       x0_i,
  input  logic [CoordBits-1:0]       y0_i,
  input  logic [CoordBits:0]         x1_i,
  input  logic [CoordBits:0]         y1_i,
  input  logic signed [CoordBits:0]  dya_i,
  input  logic signed [CoordBits:0]  dxb_i,
  input  sri_pkg::geom_flags_t       flags_i,
  input  logic [CoordBits-1:0]       ax_i,
  input  logic [CoordBits-1:0]       ay_i,
  input  logic [CoordBits-1:0]       bx_i,
  input  logic [CoordBits-1:0]       by_i,
  output logic                       valid_o,
  output sri_pkg::geom_flags_t       flags_o,
  output sri_pkg::corner_sign_t      sign_o
);
  import sri_pkg::*;

  localparam int unsigned OpBits   = CoordBits + 2;
  localparam int unsigned ProdBits = 2 * OpBits;
  localparam int unsigned KBits    = 2 * CoordBits;

  // corner cross product: K + px*(ay-by) + py*(bx-ax), K = ax*by - ay*bx
  logic signed [OpBits-1:0]   x0_s, x1_s, y0_s, y1_s, dya_s, dxb_s;
  logic signed [ProdBits-1:0] px0_q, px1_q, py0_q, py1_q;
  logic [KBits-1:0]           kpos_q, kneg_q;
  logic                       valid2_q, valid3_q;
  geom_flags_t                flags2_q, flags3_q;

  logic signed [ProdBits-1:0] k_s;
  logic signed [ProdBits-1:0] cross_c [4];
  corner_sign_t               sign_d, sign_q;

  always_comb begin
    x0_s  = $signed({2'b00, x0_i});
    y0_s  = $signed({2'b00, y0_i});
    x1_s  = $signed({1'b0, x1_i});
    y1_s  = $signed({1'b0, y1_i});
    dya_s = {dya_i[CoordBits], dya_i};
    dxb_s = {dxb_i[CoordBits], dxb_i};
  end

  // products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid_i;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px0_q    <= x0_s * dya_s;
      px1_q    <= x1_s * dya_s;
      py0_q    <= y0_s * dxb_s;
      py1_q    <= y1_s * dxb_s;
      kpos_q   <= ax_i * by_i;
      kneg_q   <= ay_i * bx_i;
      flags2_q <= flags_i;
    end
  end

  // sums and signs
  always_comb begin
    k_s = $signed({{(ProdBits-KBits){1'b0}}, kpos_q}) -
          $signed({{(ProdBits-KBits){1'b0}}, kneg_q});
    cross_c[0] = k_s + px0_q + py0_q;
    cross_c[1] = k_s + px1_q + py0_q;
    cross_c[2] = k_s + px1_q + py1_q;
    cross_c[3] = k_s + px0_q + py1_q;
    for (int i = 0; i < 4; i++) begin
      sign_d.neg[i] = cross_c[i][ProdBits-1];
      sign_d.pos[i] = !cross_c[i][ProdBits-1] && (cross_c[i] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign_q   <= sign_d;
      flags3_q <= flags2_q;
    end
  end

  assign valid_o = valid3_q;
  assign flags_o = flags3_q;
  assign sign_o  = sign_q;

endmodule

### rtl/core/segment_rectangle_intersect.sv
// channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------------
// box in   | in_valid_i / in_ready_o  | box_left_i box_top_i box_width_i box_height_i
// result   | out_valid_o / out_ready_i| hit_o endpoint_inside_o edge_crossed_o
// config   | cfg_we_i (no wait)       | cfg_index_i cfg_wdata_i
//
// one rectangle per cycle when nothing stalls; four register stages (corners, products,
// corner signs, output) lie between an accepted beat and its result
// the whole pipe advances together and halts while the output beat is not taken
// reset clears the line registers to zero and empties the pipe
module segment_rectangle_intersect #(
  parameter int unsigned CoordBits = sri_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sri_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [CoordBits-1:0]              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [CoordBits-1:0]              box_left_i,
  input  logic [CoordBits-1:0]              box_top_i,
  input  logic [CoordBits-1:0]              box_width_i,
  input  logic [CoordBits-1:0]              box_height_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic                              endpoint_inside_o,
  output logic                              edge_crossed_o
);
  import sri_pkg::*;

  logic [CoordBits-1:0]      ax_q, ay_q, bx_q, by_q;
  logic                      en;
  logic                      v1, v3;
  logic [CoordBits-1:0]      x0, y0;
  logic [CoordBits:0]        x1, y1;
  logic signed [CoordBits:0] dya, dxb;
  geom_flags_t               flags1, flags3;
  corner_sign_t              sign3;
  logic [3:0]                edge_hit;
  logic                      crossed_d;
  logic                      out_valid_q, hit_q, inside_q, crossed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q <= '0;
      ay_q <= '0;
      bx_q <= '0;
      by_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_START_X: ax_q <= cfg_wdata_i;
        REG_START_Y: ay_q <= cfg_wdata_i;
        REG_END_X:   bx_q <= cfg_wdata_i;
        REG_END_Y:   by_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  sri_setup #(
    .CoordBits(CoordBits)
  ) u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .box_left_i  (box_left_i),
    .box_top_i   (box_top_i),
    .box_width_i (box_width_i),
    .box_height_i(box_height_i),
    .ax_i        (ax_q),
    .ay_i        (ay_q),
    .bx_i        (bx_q),
    .by_i        (by_q),
    .valid_o     (v1),
    .x0_o        (x0),
    .y0_o        (y0),
    .x1_o        (x1),
    .y1_o        (y1),
    .dya_o       (dya),
    .dxb_o       (dxb),
    .flags_o     (flags1)
  );

  sri_cross #(
    .CoordBits(CoordBits)
  ) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v1),
    .x0_i   (x0),
    .y0_i   (y0),
    .x1_i   (x1),
    .y1_i   (y1),
    .dya_i  (dya),
    .dxb_i  (dxb),
    .flags_i(flags1),
    .ax_i   (ax_q),
    .ay_i   (ay_q),
    .bx_i   (bx_q),
    .by_i   (by_q),
    .valid_o(v3),
    .flags_o(flags3),
    .sign_o (sign3)
  );

  // edge i runs from corner i to corner i+1; it misses when its ends lie
  // strictly on one side of the alarm line
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      edge_hit[i] = !flags3.reject[i] &&
                    !((sign3.pos[i] && sign3.pos[(i + 1) % 4]) ||
                      (sign3.neg[i] && sign3.neg[(i + 1) % 4]));
    end
    crossed_d = |edge_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q     <= flags3.pt_in || crossed_d;
      inside_q  <= flags3.pt_in;
      crossed_q <= crossed_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hit_o             = hit_q;
  assign endpoint_inside_o = inside_q;
  assign edge_crossed_o    = crossed_q;

  a_ready_drop_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output beat");

  a_beat_enters_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1)
    else $error("accepted beat missing from first stage");

  a_last_stage_to_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v3) |=> out_valid_o)
    else $error("result lost between last stage and output register");

endmodule
